// File: rtl/core/fixed_block_free_list_allocator_unit_defines.svh
// Assertion macros for the block pool allocator.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FBFLA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FBFLA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FBFLA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FBFLA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/fbfla_pkg.sv
// Shared constants and control types for the block pool allocator.
package fbfla_pkg;
  localparam int MAX_BLOCKS_DEF = 256;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;
  localparam int CNT_CFG_W = 9;
  localparam int BYTES_W = 17;
  localparam int IDX_IN_W = 8;
  localparam int OFFSET_W = 24;
  localparam int STATUS_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

  localparam logic [CNT_CFG_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [BYTES_W-1:0] MIN_BYTES = 17'd8;
  localparam logic [BYTES_W-1:0] MAX_BYTES = 17'd65536;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic accept;
    logic exec;
  } fbfla_cmd_t;

  typedef struct packed {
    logic slot_free;
  } fbfla_sts_t;
endpackage

// File: rtl/core/fbfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbfla_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/fbfla_ctrl.sv
// Controller: sequences accept and execute of one transaction at a time.
module fbfla_ctrl import fbfla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  fbfla_sts_t sts,
  output fbfla_cmd_t cmd
);
  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (sts.slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign cmd.accept = (state == S_IDLE) && in_valid;
  assign cmd.exec   = (state == S_EXEC) && sts.slot_free;
endmodule

// File: rtl/core/fbfla_dp.sv
// Datapath: free list head, watermark, link RAM, offset multiply, result register.
module fbfla_dp import fbfla_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  opcode,
  input  logic [IDX_IN_W-1:0]   block_index,
  input  fbfla_cmd_t            cmd,
  output fbfla_sts_t            sts,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [IDX_IN_W-1:0]   granted_index,
  output logic [OFFSET_W-1:0]   byte_offset,
  output logic [STATUS_W-1:0]   status
);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int HW = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W = IDX_W + BYTES_W;
  localparam logic [HW-1:0] EMPTY_HEAD = HW'(MAX_BLOCKS);

  logic                 op_q;
  logic [IDX_IN_W-1:0]  idx_q;
  logic [HW-1:0]        head;
  logic [HW-1:0]        mark;
  logic [HW-1:0]        count;
  logic [BYTES_W-1:0]   eff;
  logic [HW-1:0]        link_rdata;

  logic [CNT_CFG_W-1:0] cnt_cfg;
  logic [HW-1:0]        count_next;
  logic [BYTES_W-1:0]   bytes_sat;
  logic [BYTES_W-1:0]   eff_next;

  logic                 head_ok;
  logic                 mark_ok;
  logic                 in_range;
  logic [IDX_W-1:0]     grant;
  logic [PROD_W-1:0]    prod;
  logic                 link_we;

  assign cnt_cfg = cfg_data[CNT_CFG_W-1:0];
  assign count_next = (32'(cnt_cfg) > 32'(MAX_BLOCKS)) ? EMPTY_HEAD : HW'(cnt_cfg);
  assign bytes_sat = (cfg_data > MAX_BYTES) ? MAX_BYTES : cfg_data;
  assign eff_next = (bytes_sat < MIN_BYTES) ? MIN_BYTES : bytes_sat;

  assign head_ok  = (head < EMPTY_HEAD);
  assign mark_ok  = (mark < count);
  assign in_range = (32'(idx_q) < 32'(count));
  assign grant    = head_ok ? head[IDX_W-1:0] : mark[IDX_W-1:0];
  assign prod     = PROD_W'(grant) * PROD_W'(eff);
  assign link_we  = cmd.exec && (op_q == OP_FREE) && in_range;

  assign sts.slot_free = !out_valid || !out_stall;

  fbfla_ram #(
    .WIDTH(HW),
    .DEPTH(MAX_BLOCKS)
  ) u_link (
    .clk  (clk),
    .we   (link_we),
    .waddr(IDX_W'(idx_q)),
    .wdata(head),
    .raddr(head[IDX_W-1:0]),
    .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= opcode;
      idx_q <= block_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= EMPTY_HEAD;
      mark  <= '0;
      count <= (32'(COUNT_RESET) > 32'(MAX_BLOCKS)) ? EMPTY_HEAD : HW'(COUNT_RESET);
      eff   <= MIN_BYTES;
    end else if (cfg_we) begin
      head <= EMPTY_HEAD;
      mark <= '0;
      unique case (cfg_index)
        CFG_BLOCK_COUNT: count <= count_next;
        CFG_BLOCK_BYTES: eff <= eff_next;
        default: ;
      endcase
    end else if (cmd.exec) begin
      if (op_q == OP_ALLOC) begin
        if (head_ok) begin
          head <= link_rdata;
        end else if (mark_ok) begin
          mark <= mark + HW'(1);
        end
      end else if (in_range) begin
        head <= HW'(idx_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      granted_index <= '0;
      byte_offset   <= '0;
      status        <= STATUS_OK;
      if (op_q == OP_ALLOC) begin
        if (head_ok || mark_ok) begin
          granted_index <= IDX_IN_W'(grant);
          byte_offset   <= OFFSET_W'(prod);
        end else begin
          status <= STATUS_EMPTY;
        end
      end else if (!in_range) begin
        status <= STATUS_RANGE;
      end
    end
  end
endmodule

// File: rtl/core/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed-size block pool allocator with a LIFO free list.
// Accept captures the transaction in the input registers; in S_EXEC it runs and
// loads the output register. No new transaction is accepted until the last one ran.
// A result waiting on out_stall holds the next transaction in its execute cycle.
// Reset: pool holds blocks 0..count-1, count 256, size 8; no clearing pass, ready at once.
module fixed_block_free_list_allocator_unit import fbfla_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [IDX_IN_W-1:0]   block_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_IN_W-1:0]   granted_index,
  output logic [OFFSET_W-1:0]   byte_offset,
  output logic [STATUS_W-1:0]   status
);
`include "fixed_block_free_list_allocator_unit_defines.svh"

  fbfla_cmd_t cmd;
  fbfla_sts_t sts;

  fbfla_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  fbfla_dp #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .block_index  (block_index),
    .cmd          (cmd),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .granted_index(granted_index),
    .byte_offset  (byte_offset),
    .status       (status)
  );

  `FBFLA_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)
  `FBFLA_ASSERT_IMP(a_no_grant_on_error, clk, rst,
    out_valid && (status != STATUS_OK), (granted_index == '0) && (byte_offset == '0))
  `FBFLA_ASSERT_IMP(a_status_legal, clk, rst, out_valid,
    (status == STATUS_OK) || (status == STATUS_EMPTY) || (status == STATUS_RANGE))
  `FBFLA_ASSERT_NXT(a_exec_loads_result, clk, rst, cmd.exec, out_valid)
endmodule
